@@ rtl/core/tpaf_pkg.sv @@
// Shared types and constants for the triac phase-angle firing unit.
`timescale 1ns / 1ps

package tpaf_pkg;

   localparam int DelayWidth = 14;
   localparam int PulseWidth = 10;
   localparam int StepWidth = 8;
   localparam int PowerWidth = 7;
   localparam int ProdWidth = PowerWidth + StepWidth;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 14;

   localparam logic [PowerWidth-1:0] FULL_POWER = 7'd100;

   localparam logic [StepWidth-1:0] RESET_DELAY_PER_PERCENT = 8'd83;
   localparam logic [DelayWidth-1:0] RESET_MIN_DELAY = 14'd250;
   localparam logic [DelayWidth-1:0] RESET_MAX_DELAY = 14'd8000;
   localparam logic [PulseWidth-1:0] RESET_PULSE_WIDTH = 10'd200;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_DELAY_PER_PERCENT = 2'd0,
      REG_MIN_DELAY = 2'd1,
      REG_MAX_DELAY = 2'd2,
      REG_PULSE_WIDTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [StepWidth-1:0] delay_per_percent;
      logic [DelayWidth-1:0] min_delay;
      logic [DelayWidth-1:0] max_delay;
      logic [PulseWidth-1:0] pulse_width;
   } cfg_type;

   typedef struct packed {
      logic gate;
      logic relay;
      logic armed;
   } result_type;

endpackage

@@ rtl/core/tpaf_csr.sv @@
// Configuration registers of the triac phase-angle firing unit.
`timescale 1ns / 1ps

module tpaf_csr
   import tpaf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_DELAY_PER_PERCENT: cfg_in.delay_per_percent = csr_data[StepWidth-1:0];
            REG_MIN_DELAY: cfg_in.min_delay = csr_data[DelayWidth-1:0];
            REG_MAX_DELAY: cfg_in.max_delay = csr_data[DelayWidth-1:0];
            REG_PULSE_WIDTH: cfg_in.pulse_width = csr_data[PulseWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_per_percent <= RESET_DELAY_PER_PERCENT;
         cfg_ff.min_delay <= RESET_MIN_DELAY;
         cfg_ff.max_delay <= RESET_MAX_DELAY;
         cfg_ff.pulse_width <= RESET_PULSE_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/tpaf_fire.sv @@
// Firing delay and gate pulse state with the per-tick result logic.
`timescale 1ns / 1ps

module tpaf_fire
   import tpaf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic zero_cross,
   input  logic [PowerWidth-1:0] power_request,
   input  cfg_type cfg,
   output result_type result
);

   logic [DelayWidth-1:0] delay_count_ff, delay_count_in;
   logic delay_active_ff, delay_active_in;
   logic [PulseWidth-1:0] pulse_count_ff, pulse_count_in;

   logic [PowerWidth-1:0] power_sat;
   logic [PowerWidth-1:0] missing;
   logic [ProdWidth-1:0] product;
   logic [ProdWidth-1:0] delay_raw;
   logic skip;
   logic [PulseWidth-1:0] pulse_pre;

   always_comb begin
      power_sat = (power_request > FULL_POWER) ? FULL_POWER : power_request;
      missing = FULL_POWER - power_sat;
      product = ProdWidth'(missing) * ProdWidth'(cfg.delay_per_percent);
      // The minimum is applied first, so a minimum above the maximum never fires.
      delay_raw = (product < ProdWidth'(cfg.min_delay)) ? ProdWidth'(cfg.min_delay) : product;
      skip = delay_raw > ProdWidth'(cfg.max_delay);

      delay_active_in = delay_active_ff;
      delay_count_in = delay_count_ff;
      pulse_pre = pulse_count_ff;

      if (zero_cross) begin
         if (skip) begin
            delay_active_in = 1'b0;
            delay_count_in = '0;
         end else if (delay_raw == '0) begin
            delay_active_in = 1'b0;
            delay_count_in = '0;
            pulse_pre = cfg.pulse_width;
         end else begin
            delay_active_in = 1'b1;
            delay_count_in = delay_raw[DelayWidth-1:0];
         end
      end else if (delay_active_ff) begin
         if (delay_count_ff <= DelayWidth'(1)) begin
            delay_active_in = 1'b0;
            delay_count_in = '0;
            pulse_pre = cfg.pulse_width;
         end else begin
            delay_count_in = delay_count_ff - DelayWidth'(1);
         end
      end

      result.gate = pulse_pre != '0;
      result.relay = power_sat != '0;
      result.armed = delay_active_in;
      pulse_count_in = result.gate ? (pulse_pre - PulseWidth'(1)) : pulse_pre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_count_ff <= '0;
         delay_active_ff <= 1'b0;
         pulse_count_ff <= '0;
      end else if (step) begin
         delay_count_ff <= delay_count_in;
         delay_active_ff <= delay_active_in;
         pulse_count_ff <= pulse_count_in;
      end
   end

`ifndef SYNTHESIS
   a_armed_has_count: assert property (@(posedge clock) disable iff (reset)
      delay_active_ff |-> delay_count_ff != '0)
      else $error("pending firing with an empty delay count");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !delay_active_ff |-> delay_count_ff == '0)
      else $error("delay count left over with no pending firing");

   a_pulse_decrements: assert property (@(posedge clock) disable iff (reset)
      step && !zero_cross && !delay_active_ff && pulse_count_ff != '0
      |=> pulse_count_ff == $past(pulse_count_ff) - PulseWidth'(1))
      else $error("gate pulse count did not run down by one");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pulse_count_ff) && $stable(delay_count_ff))
      else $error("firing state changed without a transaction");
`endif

endmodule

@@ rtl/core/triac_phase_angle_firing_unit.sv @@
// Top level of the triac phase-angle firing unit: input and result registers.
`timescale 1ns / 1ps

// Each request transaction is one microsecond tick carrying the mains
// zero-cross flag and the requested power in percent. Each one yields exactly
// one response transaction with the gate drive, relay and armed flags.
// The request is captured in an input register; the firing logic (one 7x8
// multiply, the delay compares and the counters) then updates its state and
// loads the response register once that register is empty or being taken, and
// one transaction is taken every cycle while the receiver keeps rsp_ready high.
// When rsp_ready is low the response register holds and the input register
// fills; req_ready then drops until the response is taken, so no tick is lost.
// Configuration registers are written through the csr_ channel, which is always
// ready; writes should be made only while no transaction is in flight.
// A synchronous reset clears the pipeline, the firing state and restores the
// default delay step, minimum, maximum and pulse width.

module triac_phase_angle_firing_unit
   import tpaf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_zero_cross,
   input  logic [PowerWidth-1:0] req_power_request,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_gate,
   output logic rsp_relay,
   output logic rsp_armed,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   cfg_type cfg;
   result_type result;

   logic in_valid_ff, in_valid_in;
   logic in_zero_cross_ff;
   logic [PowerWidth-1:0] in_power_ff;
   logic out_valid_ff, out_valid_in;
   result_type out_result_ff;

   logic advance;
   logic step;
   logic req_take;

   assign csr_ready = 1'b1;

   tpaf_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   tpaf_fire u_fire (
      .clock(clock),
      .reset(reset),
      .step(step),
      .zero_cross(in_zero_cross_ff),
      .power_request(in_power_ff),
      .cfg(cfg),
      .result(result)
   );

   always_comb begin
      advance = !out_valid_ff || rsp_ready;
      step = in_valid_ff && advance;
      req_ready = !in_valid_ff || advance;
      req_take = req_valid && req_ready;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_zero_cross_ff <= req_zero_cross;
         in_power_ff <= req_power_request;
      end
      if (step) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_gate = out_result_ff.gate;
   assign rsp_relay = out_result_ff.relay;
   assign rsp_armed = out_result_ff.armed;

endmodule
